FILE: hw/rtl/xcrc_pkg.sv
// xcrc_pkg: shared types and constants for the XMODEM-CRC receiver.
// Holds beat structs, the phase and result-kind enums and protocol symbols.
// No dependencies.
package xcrc_pkg;

	localparam int BLOCK_BYTES   = 128;
	localparam int INDEX_BITS    = $clog2(BLOCK_BYTES);
	localparam int ADDR_OUT_BITS = 16;

	localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(BLOCK_BYTES - 1);

	// protocol symbols
	localparam logic [7:0] SYM_SOH = 8'h01;
	localparam logic [7:0] SYM_EOT = 8'h04;
	localparam logic [7:0] SYM_ACK = 8'h06;
	localparam logic [7:0] SYM_NAK = 8'h15;
	localparam logic [7:0] SYM_REQ = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	// configuration reset values
	localparam logic [7:0] RETRY_TICKS_RST  = 8'd200;
	localparam logic [7:0] DOWNLOAD_KEY_RST = 8'd100;

	// configuration register indexes
	localparam logic REG_RETRY_TICKS  = 1'b0;
	localparam logic REG_DOWNLOAD_KEY = 1'b1;

	// input action codes
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_KEY,
		PH_SOH,
		PH_BLK,
		PH_CPL,
		PH_DATA,
		PH_CRCH,
		PH_CRCL,
		PH_HDR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_LAUNCH = 2'd2
	} kind_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		kind_t                    kind;
		logic [7:0]               tx_byte;
		logic [7:0]               data_byte;
		logic [ADDR_OUT_BITS-1:0] data_address;
		logic                     block_good;
		logic                     block_bad;
		logic                     session_end;
	} out_beat_t;

endpackage

FILE: hw/rtl/xmodem_crc_receiver.sv
// xmodem_crc_receiver: XMODEM-CRC download receiver, one beat per cycle.
// Results are registered: a result appears on out_valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; in_ready drops only while a result is held
// in the output register and out_ready is low.
// Reset (arst_n low, asynchronous): wait for the start key, registers at their
// defaults (retry_ticks 200, download_key 100), output register empty.
module xmodem_crc_receiver #(
	parameter int ADDRESS_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  xcrc_pkg::in_beat_t  in_data,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output xcrc_pkg::out_beat_t out_data,
	// configuration write port
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_wdata
);

	// Address math runs at ADDRESS_BITS; the result field is fixed at 16 bits,
	// so widen to at least 16 before taking the low bits.
	localparam int ADDR_EXT_BITS = (ADDRESS_BITS > xcrc_pkg::ADDR_OUT_BITS) ?
		ADDRESS_BITS : xcrc_pkg::ADDR_OUT_BITS;
	localparam int IW = xcrc_pkg::INDEX_BITS;

	// configuration registers
	logic [7:0] retry_ticks_q;
	logic [7:0] download_key_q;

	// protocol state
	xcrc_pkg::phase_t  phase_q, phase_d;
	logic [7:0]        tick_count_q, tick_count_d;
	logic [7:0]        expected_block_q, expected_block_d;
	logic [IW-1:0]     byte_index_q, byte_index_d;
	logic [15:0]       running_crc_q, running_crc_d;
	logic [7:0]        crc_high_q, crc_high_d;
	logic [ADDRESS_BITS-1:0] base_addr_q, base_addr_d;

	// output register
	logic                out_valid_q;
	xcrc_pkg::out_beat_t out_data_q;

	logic                accept;
	logic                res_valid;
	xcrc_pkg::out_beat_t res;
	logic                do_clear;
	logic [15:0]         crc_next;
	logic [ADDRESS_BITS-1:0]  byte_addr;
	logic [ADDR_EXT_BITS-1:0] byte_addr_ext;

	// Take a new beat whenever the output register is empty or being drained.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Running CRC over the data bytes of the current block.
	xcrc_crc16_byte u_crc (
		.crc_in  (running_crc_q),
		.data_in (in_data.rx_byte),
		.crc_out (crc_next)
	);

	assign byte_addr     = base_addr_q + ADDRESS_BITS'(byte_index_q);
	assign byte_addr_ext = ADDR_EXT_BITS'(byte_addr);

	// Load a configuration register on every write; the sender keeps writes
	// to gaps with nothing in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_ticks_q  <= xcrc_pkg::RETRY_TICKS_RST;
			download_key_q <= xcrc_pkg::DOWNLOAD_KEY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xcrc_pkg::REG_RETRY_TICKS:  retry_ticks_q  <= cfg_wdata;
				xcrc_pkg::REG_DOWNLOAD_KEY: download_key_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next state and result for the accepted beat.
	always_comb begin
		phase_d          = phase_q;
		tick_count_d     = tick_count_q;
		expected_block_d = expected_block_q;
		byte_index_d     = byte_index_q;
		running_crc_d    = running_crc_q;
		crc_high_d       = crc_high_q;
		base_addr_d      = base_addr_q;
		res              = '0;
		res_valid        = 1'b0;
		do_clear         = 1'b0;

		if (accept) begin
			if (in_data.action == xcrc_pkg::ACT_TICK) begin
				// Ticks only matter while requesting the first block.
				if (phase_q == xcrc_pkg::PH_SOH) begin
					if (tick_count_q == retry_ticks_q) begin
						res_valid    = 1'b1;
						res.kind     = xcrc_pkg::KIND_TX;
						res.tx_byte  = xcrc_pkg::SYM_REQ;
						tick_count_d = 8'd1;
					end else begin
						tick_count_d = tick_count_q + 8'd1;
					end
				end
			end else begin
				unique case (phase_q)
					xcrc_pkg::PH_KEY: begin
						if (in_data.rx_byte != download_key_q) begin
							do_clear  = 1'b1;
							res_valid = 1'b1;
							res.kind  = xcrc_pkg::KIND_LAUNCH;
						end else begin
							phase_d = xcrc_pkg::PH_SOH;
						end
					end
					xcrc_pkg::PH_SOH: begin
						if (in_data.rx_byte == xcrc_pkg::SYM_SOH) begin
							expected_block_d = 8'd1;
							base_addr_d      = '0;
							phase_d          = xcrc_pkg::PH_BLK;
						end
					end
					xcrc_pkg::PH_BLK: begin
						if (in_data.rx_byte == expected_block_q) begin
							phase_d = xcrc_pkg::PH_CPL;
						end else begin
							phase_d     = xcrc_pkg::PH_HDR;
							res_valid   = 1'b1;
							res.kind    = xcrc_pkg::KIND_TX;
							res.tx_byte = xcrc_pkg::SYM_NAK;
						end
					end
					xcrc_pkg::PH_CPL: begin
						if (~in_data.rx_byte == expected_block_q) begin
							byte_index_d  = '0;
							running_crc_d = '0;
							phase_d       = xcrc_pkg::PH_DATA;
						end else begin
							phase_d = xcrc_pkg::PH_HDR;
						end
					end
					xcrc_pkg::PH_DATA: begin
						res_valid        = 1'b1;
						res.kind         = xcrc_pkg::KIND_DATA;
						res.data_byte    = in_data.rx_byte;
						res.data_address = byte_addr_ext[xcrc_pkg::ADDR_OUT_BITS-1:0];
						running_crc_d    = crc_next;
						byte_index_d     = byte_index_q + IW'(1);
						if (byte_index_q == xcrc_pkg::LAST_INDEX) begin
							phase_d = xcrc_pkg::PH_CRCH;
						end
					end
					xcrc_pkg::PH_CRCH: begin
						crc_high_d = in_data.rx_byte;
						phase_d    = xcrc_pkg::PH_CRCL;
					end
					xcrc_pkg::PH_CRCL: begin
						phase_d   = xcrc_pkg::PH_HDR;
						res_valid = 1'b1;
						res.kind  = xcrc_pkg::KIND_TX;
						if ({crc_high_q, in_data.rx_byte} == running_crc_q) begin
							base_addr_d      = base_addr_q +
								ADDRESS_BITS'(xcrc_pkg::BLOCK_BYTES);
							expected_block_d = expected_block_q + 8'd1;
							res.tx_byte      = xcrc_pkg::SYM_ACK;
							res.block_good   = 1'b1;
						end else begin
							res.tx_byte   = xcrc_pkg::SYM_NAK;
							res.block_bad = 1'b1;
						end
					end
					xcrc_pkg::PH_HDR: begin
						// EOT ends the session; anything else is taken as SOH.
						if (in_data.rx_byte == xcrc_pkg::SYM_EOT) begin
							do_clear        = 1'b1;
							res_valid       = 1'b1;
							res.kind        = xcrc_pkg::KIND_TX;
							res.tx_byte     = xcrc_pkg::SYM_ACK;
							res.session_end = 1'b1;
						end else begin
							phase_d = xcrc_pkg::PH_BLK;
						end
					end
					default: do_clear = 1'b1;
				endcase
			end
		end

		// Launch and session end drop back to the start-key wait.
		if (do_clear) begin
			phase_d          = xcrc_pkg::PH_KEY;
			tick_count_d     = '0;
			expected_block_d = 8'd1;
			byte_index_d     = '0;
			running_crc_d    = '0;
			crc_high_d       = '0;
			base_addr_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= xcrc_pkg::PH_KEY;
			tick_count_q     <= '0;
			expected_block_q <= 8'd1;
			byte_index_q     <= '0;
			running_crc_q    <= '0;
			crc_high_q       <= '0;
			base_addr_q      <= '0;
		end else begin
			phase_q          <= phase_d;
			tick_count_q     <= tick_count_d;
			expected_block_q <= expected_block_d;
			byte_index_q     <= byte_index_d;
			running_crc_q    <= running_crc_d;
			crc_high_q       <= crc_high_d;
			base_addr_q      <= base_addr_d;
		end
	end

	// Output register: load on every accepted beat, drop when drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule

FILE: hw/rtl/xcrc_crc16_byte.sv
// xcrc_crc16_byte: one-byte CRC-16 update, polynomial 0x1021, MSB first.
// Depends on xcrc_pkg for the polynomial constants.
module xcrc_crc16_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data_in,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data_in, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & xcrc_pkg::CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ xcrc_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

FILE: hw/rtl/xcrc_checker.sv
// xcrc_checker: port-level checks for xmodem_crc_receiver, bound to the top level.
// Depends on xcrc_pkg for beat types.
module xcrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input xcrc_pkg::out_beat_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// A full, stalled output stage must back-pressure the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// A result only follows an accepted input beat or a held result.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result beat without an input beat");

endmodule

bind xmodem_crc_receiver xcrc_checker u_xcrc_checker (.*);

FILE: sim/tb.sv
// tb: self-checking bench for xmodem_crc_receiver (XMODEM-CRC download receiver).
// A table of directed beats runs first, then random download sessions, checked
// against an in-bench model or pinned rows. Depends on xcrc_pkg and the RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_BITS    = 16;
	localparam int RANDOM_BEATS = 1750;
	localparam int STALL_LIMIT  = 4000;
	localparam int CALM_BEATS   = 300;

	// how a directed row gets its expectation
	typedef enum logic [1:0] {
		BY_MODEL,
		NO_RESULT,
		FIXED_RESULT
	} row_check_t;

	typedef struct {
		xcrc_pkg::in_beat_t  beat;
		row_check_t          check;
		xcrc_pkg::out_beat_t pinned;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	xcrc_pkg::in_beat_t  in_data;
	logic                out_valid;
	logic                out_ready = 1'b0;
	xcrc_pkg::out_beat_t out_data;
	logic                cfg_we;
	logic                cfg_index;
	logic [7:0]          cfg_wdata;

	// expectation attached to the beat currently on in_data
	row_check_t          cur_check = BY_MODEL;
	xcrc_pkg::out_beat_t cur_pinned = '0;

	// model copy of the receiver: configuration and protocol state
	logic [7:0]                      retry_cfg;
	logic [7:0]                      key_cfg;
	xcrc_pkg::phase_t                rx_phase;
	logic [7:0]                      tick_cnt;
	logic [7:0]                      want_blk;
	logic [xcrc_pkg::INDEX_BITS-1:0] data_pos;
	logic [15:0]                     crc_acc;
	logic [7:0]                      crc_hi;
	logic [ADDR_BITS-1:0]            base_addr;

	xcrc_pkg::out_beat_t pending_replies[$];
	stim_row_t           directed_rows[$];
	int                  reconfig_row;
	int                  errors = 0;
	int                  replies_seen = 0;
	int                  beats_sent = 0;
	int                  quiet_cycles = 0;
	bit                  calm = 1'b0;
	bit                  mon_got;
	xcrc_pkg::out_beat_t mon_reply;

	xmodem_crc_receiver #(
		.ADDRESS_BITS(ADDR_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Receiver model
	// ------------------------------------------------------------------

	function automatic xcrc_pkg::out_beat_t reply(xcrc_pkg::kind_t k, logic [7:0] tx,
			logic [7:0] data, logic [15:0] addr, logic good, logic bad, logic fin);
		xcrc_pkg::out_beat_t r;
		r              = '0;
		r.kind         = k;
		r.tx_byte      = tx;
		r.data_byte    = data;
		r.data_address = addr;
		r.block_good   = good;
		r.block_bad    = bad;
		r.session_end  = fin;
		return r;
	endfunction

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ xcrc_pkg::CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// back to the start-key wait; registers are untouched
	function automatic void clear_receiver();
		rx_phase  = xcrc_pkg::PH_KEY;
		tick_cnt  = '0;
		want_blk  = 8'd1;
		data_pos  = '0;
		crc_acc   = '0;
		crc_hi    = '0;
		base_addr = '0;
	endfunction

	// advance the model by one accepted beat; got says whether a reply is due
	task automatic receiver_step(input xcrc_pkg::in_beat_t b, output bit got,
			output xcrc_pkg::out_beat_t r);
		got = 1'b0;
		r   = '0;
		if (b.action == xcrc_pkg::ACT_TICK) begin
			// ticks matter only while waiting for the first SOH
			if (rx_phase == xcrc_pkg::PH_SOH) begin
				if (tick_cnt == retry_cfg) begin
					got      = 1'b1;
					r        = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_REQ, 8'h00, 16'h0,
						1'b0, 1'b0, 1'b0);
					tick_cnt = '0;
				end
				tick_cnt = tick_cnt + 8'd1;
			end
			return;
		end
		case (rx_phase)
			xcrc_pkg::PH_KEY: begin
				if (b.rx_byte != key_cfg) begin
					clear_receiver();
					got = 1'b1;
					r   = reply(xcrc_pkg::KIND_LAUNCH, 8'h00, 8'h00, 16'h0,
						1'b0, 1'b0, 1'b0);
				end else begin
					rx_phase = xcrc_pkg::PH_SOH;
				end
			end
			xcrc_pkg::PH_SOH: begin
				if (b.rx_byte == xcrc_pkg::SYM_SOH) begin
					want_blk  = 8'd1;
					base_addr = '0;
					rx_phase  = xcrc_pkg::PH_BLK;
				end
			end
			xcrc_pkg::PH_BLK: begin
				if (b.rx_byte == want_blk) begin
					rx_phase = xcrc_pkg::PH_CPL;
				end else begin
					rx_phase = xcrc_pkg::PH_HDR;
					got      = 1'b1;
					r        = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_NAK, 8'h00, 16'h0,
						1'b0, 1'b0, 1'b0);
				end
			end
			xcrc_pkg::PH_CPL: begin
				if (~b.rx_byte == want_blk) begin
					data_pos = '0;
					crc_acc  = '0;
					rx_phase = xcrc_pkg::PH_DATA;
				end else begin
					rx_phase = xcrc_pkg::PH_HDR;
				end
			end
			xcrc_pkg::PH_DATA: begin
				got = 1'b1;
				r   = reply(xcrc_pkg::KIND_DATA, 8'h00, b.rx_byte,
					16'(base_addr + ADDR_BITS'(data_pos)), 1'b0, 1'b0, 1'b0);
				crc_acc = crc16_step(crc_acc, b.rx_byte);
				if (data_pos == xcrc_pkg::LAST_INDEX) begin
					rx_phase = xcrc_pkg::PH_CRCH;
				end
				data_pos = data_pos + 1'b1;
			end
			xcrc_pkg::PH_CRCH: begin
				crc_hi   = b.rx_byte;
				rx_phase = xcrc_pkg::PH_CRCL;
			end
			xcrc_pkg::PH_CRCL: begin
				rx_phase = xcrc_pkg::PH_HDR;
				got      = 1'b1;
				if ({crc_hi, b.rx_byte} == crc_acc) begin
					base_addr = base_addr + ADDR_BITS'(xcrc_pkg::BLOCK_BYTES);
					want_blk  = want_blk + 8'd1;
					r = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_ACK, 8'h00, 16'h0,
						1'b1, 1'b0, 1'b0);
				end else begin
					r = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_NAK, 8'h00, 16'h0,
						1'b0, 1'b1, 1'b0);
				end
			end
			xcrc_pkg::PH_HDR: begin
				// EOT closes the session; anything else is taken as a header
				if (b.rx_byte == xcrc_pkg::SYM_EOT) begin
					clear_receiver();
					got = 1'b1;
					r   = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_ACK, 8'h00, 16'h0,
						1'b0, 1'b0, 1'b1);
				end else begin
					rx_phase = xcrc_pkg::PH_BLK;
				end
			end
			default: begin
				clear_receiver();
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report(input string msg);
		errors++;
		$display("tb: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report($sformatf("reply %0d: %s is %h, model says %h",
				replies_seen, name, got, want));
		end
	endtask

	task automatic check_reply(input xcrc_pkg::out_beat_t got);
		xcrc_pkg::out_beat_t want;
		if (pending_replies.size() == 0) begin
			report($sformatf("reply %0d (kind %0d) arrived with nothing expected",
				replies_seen, got.kind));
			return;
		end
		want = pending_replies.pop_front();
		check_field("kind", {14'b0, got.kind}, {14'b0, want.kind});
		check_field("tx_byte", {8'b0, got.tx_byte}, {8'b0, want.tx_byte});
		check_field("data_byte", {8'b0, got.data_byte}, {8'b0, want.data_byte});
		check_field("data_address", got.data_address, want.data_address);
		check_field("block_good", {15'b0, got.block_good}, {15'b0, want.block_good});
		check_field("block_bad", {15'b0, got.block_bad}, {15'b0, want.block_bad});
		check_field("session_end", {15'b0, got.session_end}, {15'b0, want.session_end});
	endtask

	// Sample both channels at the rising edge. Check the outgoing beat first:
	// a beat accepted on input at this edge can only reply on a later one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				check_reply(out_data);
				replies_seen++;
			end
			if (in_valid && in_ready) begin
				receiver_step(in_data, mon_got, mon_reply);
				if (cur_check == FIXED_RESULT) begin
					pending_replies.push_back(cur_pinned);
				end else if (cur_check == BY_MODEL && mon_got) begin
					pending_replies.push_back(mon_reply);
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Receiver side: drop out_ready with a chance of about 28 in a hundred, never while calm.
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 28);
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Call at a falling edge; returns at the falling edge after acceptance
	// with valid still high; valid drops between beats only for random gaps outside calm.
	task automatic send_beat(input xcrc_pkg::in_beat_t b, input row_check_t chk,
			input xcrc_pkg::out_beat_t pinned);
		bit counts;
		// ignored ticks and junk before SOH don't count toward the budget
		counts = !(b.action == xcrc_pkg::ACT_TICK && rx_phase != xcrc_pkg::PH_SOH)
			&& !(b.action == xcrc_pkg::ACT_BYTE && rx_phase == xcrc_pkg::PH_SOH
			&& b.rx_byte != xcrc_pkg::SYM_SOH);
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		in_data    <= b;
		cur_check  <= chk;
		cur_pinned <= pinned;
		do begin
			@(posedge clk);
		end while (in_ready !== 1'b1);
		@(negedge clk);
		if (counts) begin
			beats_sent++;
		end
	endtask

	task automatic send_tick();
		xcrc_pkg::in_beat_t t;
		t.action  = xcrc_pkg::ACT_TICK;
		t.rx_byte = 8'($urandom);
		send_beat(t, BY_MODEL, '0);
	endtask

	// a received byte, now and then preceded by a stray tick
	task automatic send_byte(input logic [7:0] b);
		xcrc_pkg::in_beat_t t;
		if ($urandom_range(24) == 0) begin
			send_tick();
		end
		t.action  = xcrc_pkg::ACT_BYTE;
		t.rx_byte = b;
		send_beat(t, BY_MODEL, '0);
	endtask

	// Hold the sender until every expected reply is back, then wait out anything
	// still in flight that produces no reply.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_replies.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == xcrc_pkg::REG_RETRY_TICKS) begin
			retry_cfg = val;
		end else begin
			key_cfg = val;
		end
		@(negedge clk);
	endtask

	// Fill the rest of an open block with random data, then send its CRC,
	// optionally with one bit flipped.
	task automatic close_block(input bit corrupt);
		logic [15:0] crc;
		while (rx_phase == xcrc_pkg::PH_DATA) begin
			send_byte(8'($urandom));
		end
		crc = crc_acc;
		if (corrupt) begin
			crc = crc ^ (16'd1 << $urandom_range(15));
		end
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
	endtask

	// One download session from the start-key wait back to it. Mostly clean
	// transfers; also launches, junk before SOH, bad numbers, bad complements,
	// bad CRCs and odd header bytes.
	task automatic run_session();
		logic [7:0] b;
		logic [7:0] num;
		int         n;
		int         nblk;
		int         pick;
		if ($urandom_range(5) == 0) begin
			do begin
				b = 8'($urandom);
			end while (b == key_cfg);
			send_byte(b);
			return;
		end
		send_byte(key_cfg);
		// wait out the 'C' schedule now and then, else a few ticks
		if ($urandom_range(3) == 0) begin
			n = int'(retry_cfg) + $urandom_range(0, 2);
		end else begin
			n = $urandom_range(0, 4);
		end
		repeat (n) begin
			if ($urandom_range(5) == 0) begin
				do begin
					b = 8'($urandom);
				end while (b == xcrc_pkg::SYM_SOH);
				send_byte(b);
			end else begin
				send_tick();
			end
		end
		send_byte(xcrc_pkg::SYM_SOH);
		nblk = $urandom_range(1, 3);
		for (int k = 0; k < nblk; k++) begin
			if (k > 0) begin
				// header slot: usually SOH, sometimes any non-EOT byte
				if ($urandom_range(7) == 0) begin
					do begin
						b = 8'($urandom);
					end while (b == xcrc_pkg::SYM_EOT);
				end else begin
					b = xcrc_pkg::SYM_SOH;
				end
				send_byte(b);
			end
			num  = want_blk;
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_byte(num ^ 8'($urandom_range(1, 255)));
			end else begin
				send_byte(num);
				if (pick < 14) begin
					send_byte(~num ^ 8'($urandom_range(1, 255)));
				end else begin
					send_byte(~num);
					close_block($urandom_range(4) == 0);
				end
			end
		end
		send_byte(xcrc_pkg::SYM_EOT);
	endtask

	function automatic logic [7:0] pick_retry();
		case ($urandom_range(3))
			0:       return 8'd1;
			1:       return 8'd255;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_key();
		case ($urandom_range(3))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_row(input logic act, input logic [7:0] b, input row_check_t chk,
			input xcrc_pkg::out_beat_t r);
		stim_row_t row;
		row.beat.action  = act;
		row.beat.rx_byte = b;
		row.check        = chk;
		row.pinned       = r;
		directed_rows.push_back(row);
	endtask

	// Directed table. Replies that are obvious from the protocol are typed
	// in; data rows further into a block go through the model.
	task automatic build_directed();
		xcrc_pkg::out_beat_t launch;
		xcrc_pkg::out_beat_t nak;
		xcrc_pkg::out_beat_t req;
		launch = reply(xcrc_pkg::KIND_LAUNCH, 8'h00, 8'h00, 16'h0, 1'b0, 1'b0, 1'b0);
		nak    = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_NAK, 8'h00, 16'h0,
			1'b0, 1'b0, 1'b0);
		req    = reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_REQ, 8'h00, 16'h0,
			1'b0, 1'b0, 1'b0);
		// reset settings: retry 200, key 100
		add_row(xcrc_pkg::ACT_TICK, 8'hA5, NO_RESULT, '0);        // tick before the key
		add_row(xcrc_pkg::ACT_BYTE, 8'hFF, FIXED_RESULT, launch); // other key: launch
		add_row(xcrc_pkg::ACT_BYTE, 8'h00, FIXED_RESULT, launch);
		add_row(xcrc_pkg::ACT_BYTE, xcrc_pkg::DOWNLOAD_KEY_RST, NO_RESULT, '0);
		add_row(xcrc_pkg::ACT_BYTE, xcrc_pkg::SYM_EOT, NO_RESULT, '0); // junk before SOH
		add_row(xcrc_pkg::ACT_TICK, 8'h5A, NO_RESULT, '0);        // far from the count
		add_row(xcrc_pkg::ACT_BYTE, xcrc_pkg::SYM_SOH, NO_RESULT, '0);
		add_row(xcrc_pkg::ACT_BYTE, 8'h02, FIXED_RESULT, nak);    // wrong block number
		add_row(xcrc_pkg::ACT_BYTE, 8'h77, NO_RESULT, '0);        // header slot, not EOT
		add_row(xcrc_pkg::ACT_BYTE, 8'h01, NO_RESULT, '0);
		add_row(xcrc_pkg::ACT_BYTE, 8'h00, NO_RESULT, '0);        // wrong complement
		add_row(xcrc_pkg::ACT_BYTE, xcrc_pkg::SYM_EOT, FIXED_RESULT,
			reply(xcrc_pkg::KIND_TX, xcrc_pkg::SYM_ACK, 8'h00, 16'h0, 1'b0, 1'b0, 1'b1));
		// retry 1, key 255 from here on
		reconfig_row = directed_rows.size();
		add_row(xcrc_pkg::ACT_BYTE, 8'hFF, NO_RESULT, '0);
		add_row(xcrc_pkg::ACT_TICK, 8'h00, NO_RESULT, '0);        // count 0 -> 1
		add_row(xcrc_pkg::ACT_TICK, 8'hFF, FIXED_RESULT, req);    // first 'C'
		add_row(xcrc_pkg::ACT_TICK, 8'h00, FIXED_RESULT, req);    // then every tick
		add_row(xcrc_pkg::ACT_BYTE, xcrc_pkg::SYM_SOH, NO_RESULT, '0);
		add_row(xcrc_pkg::ACT_BYTE, 8'h01, NO_RESULT, '0);
		add_row(xcrc_pkg::ACT_BYTE, 8'hFE, NO_RESULT, '0);
		// EOT inside data is data
		add_row(xcrc_pkg::ACT_BYTE, xcrc_pkg::SYM_EOT, FIXED_RESULT,
			reply(xcrc_pkg::KIND_DATA, 8'h00, xcrc_pkg::SYM_EOT, 16'h0,
			1'b0, 1'b0, 1'b0));
		add_row(xcrc_pkg::ACT_BYTE, 8'hFF, BY_MODEL, '0);
		add_row(xcrc_pkg::ACT_TICK, 8'h33, NO_RESULT, '0);        // tick mid-block ignored
		add_row(xcrc_pkg::ACT_BYTE, 8'h00, BY_MODEL, '0);
	endtask

	initial begin
		int sess;
		int calm_until;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_index  = xcrc_pkg::REG_RETRY_TICKS;
		cfg_wdata  = 8'h00;
		retry_cfg  = xcrc_pkg::RETRY_TICKS_RST;
		key_cfg    = xcrc_pkg::DOWNLOAD_KEY_RST;
		calm_until = 0;
		clear_receiver();
		build_directed();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table; switch settings once, with the block idle
		for (int i = 0; i < directed_rows.size(); i++) begin
			if (i == reconfig_row) begin
				drain();
				write_reg(xcrc_pkg::REG_RETRY_TICKS, 8'd1);
				write_reg(xcrc_pkg::REG_DOWNLOAD_KEY, 8'd255);
			end
			send_beat(directed_rows[i].beat, directed_rows[i].check,
				directed_rows[i].pinned);
		end
		// finish the block the table left open and end the session
		close_block(1'b0);
		send_byte(xcrc_pkg::SYM_EOT);

		// random sessions; reconfigure between some of them, one calm stretch
		// that runs whole sessions until enough beats have gone through
		sess = 0;
		while (beats_sent < RANDOM_BEATS) begin
			if (sess > 0 && $urandom_range(2) == 0) begin
				drain();
				write_reg(xcrc_pkg::REG_RETRY_TICKS, pick_retry());
				write_reg(xcrc_pkg::REG_DOWNLOAD_KEY, pick_key());
			end
			if (sess == 2) begin
				calm_until = beats_sent + CALM_BEATS;
			end
			calm = (sess >= 2) && (beats_sent < calm_until);
			run_session();
			sess++;
		end
		calm = 1'b0;

		// drop valid, let the last replies come home, then a short tail
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
